### rtl/core/tpbe_pkg.sv
package tpbe_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ORDER_W   = 2;
  localparam int unsigned MAX_ORDER = 3;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CNT_W     = $clog2(MAX_ORDER + 1);
  localparam int unsigned PROD_W    = 2 * DATA_W;

  typedef logic [DATA_W-1:0] fx_t;

  // Status of one fixed-point multiplication.
  typedef struct packed {
    fx_t  result;
    logic clamp;
  } mul_res_t;

endpackage

### rtl/core/truncated_power_basis_eval.sv
// The result of a last term is written to the output register after the
// sequencer has applied the term's saturated order (0 for a killed term) in
// multiplications; the input stalls until the term is done. The single shared
// 32x32 multiplier applies the power one factor per cycle.
// Reset: asynchronous, active low; clears the running product, the kill and
// saturation flags, the sequencer and the output register.
module truncated_power_basis_eval (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [tpbe_pkg::DATA_W-1:0] term_value_i,
  input  logic signed [tpbe_pkg::DATA_W-1:0] term_cutoff_i,
  input  logic [tpbe_pkg::ORDER_W-1:0]      term_order_i,
  input  logic [tpbe_pkg::DATA_W-1:0]       start_value_i,
  input  logic                              first_term_i,
  input  logic                              last_term_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tpbe_pkg::DATA_W-1:0]       basis_value_o,
  output logic                              nonzero_o,
  output logic                              saturated_o
);

  typedef enum logic [0:0] {S_IDLE, S_MUL} state_e;

  state_e                   state_q, state_d;
  logic [tpbe_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_init;
  tpbe_pkg::fx_t            prod_q, prod_d;
  tpbe_pkg::fx_t            diff_q, diff_d;
  logic                     killed_q, killed_d;
  logic                     ovf_q, ovf_d;
  logic                     last_q, last_d;
  logic                     out_valid_q, out_valid_d;
  tpbe_pkg::fx_t            out_value_q, out_value_d;
  logic                     out_nz_q, out_nz_d;
  logic                     out_sat_q, out_sat_d;
  tpbe_pkg::mul_res_t       mul_res;

  tpbe_fx_mul u_mul (
    .a_i   (prod_q),
    .b_i   (diff_q),
    .res_o (mul_res)
  );

  always_comb begin
    if (int'(term_order_i) > int'(tpbe_pkg::MAX_ORDER)) begin
      cnt_init = tpbe_pkg::CNT_W'(tpbe_pkg::MAX_ORDER);
    end else begin
      cnt_init = tpbe_pkg::CNT_W'(term_order_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    diff_d      = diff_q;
    killed_d    = killed_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_nz_d    = out_nz_q;
    out_sat_d   = out_sat_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (first_term_i) begin
            prod_d   = start_value_i;
            killed_d = 1'b0;
            ovf_d    = 1'b0;
          end
          if (!killed_d && (term_value_i < term_cutoff_i)) begin
            killed_d = 1'b1;
          end
          cnt_d   = killed_d ? '0 : cnt_init;
          diff_d  = $unsigned(term_value_i - term_cutoff_i);
          last_d  = last_term_i;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_q != '0) begin
          prod_d = mul_res.result;
          ovf_d  = ovf_q | mul_res.clamp;
          cnt_d  = cnt_q - tpbe_pkg::CNT_W'(1);
        end else if (!last_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          // The output register is free or drains this cycle.
          out_valid_d = 1'b1;
          out_value_d = killed_q ? '0 : prod_q;
          out_nz_d    = !killed_q && (prod_q != '0);
          out_sat_d   = !killed_q && ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      prod_q      <= '0;
      diff_q      <= '0;
      killed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_nz_q    <= 1'b0;
      out_sat_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prod_q      <= prod_d;
      diff_q      <= diff_d;
      killed_q    <= killed_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      out_nz_q    <= out_nz_d;
      out_sat_q   <= out_sat_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign basis_value_o = out_value_q;
  assign nonzero_o     = out_nz_q;
  assign saturated_o   = out_sat_q;

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_MUL)
    else $error("accepted transaction did not start the multiply sequence");

  a_count_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> state_q == S_MUL)
    else $error("pending multiplications while idle");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL && cnt_q != '0 |=> cnt_q == $past(cnt_q) - tpbe_pkg::CNT_W'(1))
    else $error("multiplication count did not step down by one");

  a_nonzero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nonzero_o == (basis_value_o != '0))
    else $error("nonzero flag disagrees with the basis value");

  a_killed_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> basis_value_o != '0 || !nonzero_o)
    else $error("saturation reported inconsistently");

endmodule

### rtl/core/tpbe_fx_mul.sv
module tpbe_fx_mul (
  input  tpbe_pkg::fx_t      a_i,
  input  tpbe_pkg::fx_t      b_i,
  output tpbe_pkg::mul_res_t res_o
);

  logic [tpbe_pkg::PROD_W-1:0] prod;

  assign prod = tpbe_pkg::PROD_W'(a_i) * tpbe_pkg::PROD_W'(b_i);

  // Any bit above the shifted 32-bit window means the value does not fit.
  assign res_o.clamp  = |prod[tpbe_pkg::PROD_W-1:tpbe_pkg::DATA_W+tpbe_pkg::FRAC_BITS];
  assign res_o.result = res_o.clamp ? '1
                      : prod[tpbe_pkg::DATA_W+tpbe_pkg::FRAC_BITS-1:tpbe_pkg::FRAC_BITS];

endmodule

### bench/truncated_power_basis_eval_tb.sv
module truncated_power_basis_eval_tb;

  localparam int unsigned ONE_FX     = 32'h0001_0000;
  localparam int unsigned NUM_ITEMS  = 650;
  localparam int unsigned STALL_PCT  = 15;
  localparam int unsigned DRAIN_GAP  = 8;
  localparam int unsigned HOLD_LEN   = 150;
  localparam int unsigned WDOG_LIMIT = 2000;

  typedef struct packed {
    tpbe_pkg::fx_t                value;
    tpbe_pkg::fx_t                cutoff;
    logic [tpbe_pkg::ORDER_W-1:0] order;
    tpbe_pkg::fx_t                start;
    logic                         first;
    logic                         last;
    logic                         drain;
  } spline_term_t;

  typedef struct packed {
    tpbe_pkg::fx_t value;
    logic          nonzero;
    logic          saturated;
  } basis_res_t;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               in_valid_i    = 1'b0;
  logic                               in_stall_o;
  logic signed [tpbe_pkg::DATA_W-1:0] term_value_i  = '0;
  logic signed [tpbe_pkg::DATA_W-1:0] term_cutoff_i = '0;
  logic [tpbe_pkg::ORDER_W-1:0]       term_order_i  = '0;
  tpbe_pkg::fx_t                      start_value_i = '0;
  logic                               first_term_i  = 1'b0;
  logic                               last_term_i   = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i   = 1'b0;
  tpbe_pkg::fx_t                      basis_value_o;
  logic                               nonzero_o;
  logic                               saturated_o;

  spline_term_t term_feed_q[$];
  basis_res_t   basis_expect_q[$];
  spline_term_t cur_term;

  // Shadow copy of the evaluator state.
  tpbe_pkg::fx_t prod_q;
  logic          dead_q;
  logic          clamp_q;

  int unsigned terms_sent, results_seen, zero_results, sat_results, fail_cnt;
  int unsigned items_built, drain_cnt, idle_cycles;
  logic        timed_out = 1'b0;

  always #10 clk_i = ~clk_i;

  truncated_power_basis_eval DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .term_value_i  (term_value_i),
    .term_cutoff_i (term_cutoff_i),
    .term_order_i  (term_order_i),
    .start_value_i (start_value_i),
    .first_term_i  (first_term_i),
    .last_term_i   (last_term_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .basis_value_o (basis_value_o),
    .nonzero_o     (nonzero_o),
    .saturated_o   (saturated_o)
  );

  // Applies one term to the shadow state; returns 1 when a result is emitted.
  function automatic bit eval_basis_term(input spline_term_t t, output basis_res_t r);
    logic [tpbe_pkg::PROD_W-1:0] wide;
    tpbe_pkg::fx_t               diff;
    int unsigned                 n;
    n = (t.order > tpbe_pkg::MAX_ORDER) ? tpbe_pkg::MAX_ORDER : t.order;
    if (t.first) begin
      prod_q  = t.start;
      dead_q  = 1'b0;
      clamp_q = 1'b0;
    end
    if (!dead_q) begin
      if ($signed(t.value) < $signed(t.cutoff)) begin
        dead_q = 1'b1;
      end else begin
        diff = t.value - t.cutoff;
        for (int k = 0; k < n; k++) begin
          wide = (tpbe_pkg::PROD_W'(prod_q) * tpbe_pkg::PROD_W'(diff)) >> tpbe_pkg::FRAC_BITS;
          if (|wide[tpbe_pkg::PROD_W-1:tpbe_pkg::DATA_W]) begin
            prod_q  = '1;
            clamp_q = 1'b1;
          end else begin
            prod_q = wide[tpbe_pkg::DATA_W-1:0];
          end
        end
      end
    end
    r.value     = dead_q ? '0 : prod_q;
    r.nonzero   = !dead_q && (prod_q != '0);
    r.saturated = !dead_q && clamp_q;
    return t.last;
  endfunction

  task automatic push_term(input tpbe_pkg::fx_t value, input tpbe_pkg::fx_t cutoff,
                           input int unsigned order, input tpbe_pkg::fx_t start,
                           input bit first, input bit last, input bit drain);
    spline_term_t t;
    t.value  = value;
    t.cutoff = cutoff;
    t.order  = order[tpbe_pkg::ORDER_W-1:0];
    t.start  = start;
    t.first  = first;
    t.last   = last;
    t.drain  = drain;
    term_feed_q = {term_feed_q, t};
    items_built++;
  endtask

  task automatic build_random_chain();
    int unsigned   len;
    tpbe_pkg::fx_t start, obs, diff;
    bit            first, last;
    bit            drain;
    drain = (items_built % 200) < 3;
    if ($urandom_range(0, 99) < 12) begin
      // Noise: unrelated field values, flags at random.
      push_term($urandom, $urandom, $urandom_range(0, 3), $urandom,
                $urandom_range(0, 1), $urandom_range(0, 1), drain);
      return;
    end
    len = $urandom_range(1, 4);
    case ($urandom_range(0, 9))
      0:       start = '0;
      1, 2:    start = $urandom;
      3:       start = $urandom_range(0, 2 * ONE_FX);
      default: start = ONE_FX;
    endcase
    for (int k = 0; k < len; k++) begin
      obs = $urandom;
      case ($urandom_range(0, 19))
        0:       diff = -$urandom_range(1, 3 * ONE_FX);
        1, 2:    diff = $urandom_range(0, 'h400);
        3:       diff = $urandom;
        default: diff = $urandom_range(0, 3 * ONE_FX);
      endcase
      first = (k == 0) ? ($urandom_range(0, 99) >= 5) : 1'b0;
      last  = (k == len - 1) ? ($urandom_range(0, 99) >= 5) : 1'b0;
      push_term(obs, obs - diff, $urandom_range(0, 3), start, first, last,
                drain && (k == 0));
    end
  endtask

  // Sender: offers queued terms and feeds every accepted transaction to the predictor.
  always @(posedge clk_i or negedge rst_ni) begin : drv_blk
    basis_res_t r;
    bit         fire;
    bit         offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        if (eval_basis_term(cur_term, r)) basis_expect_q = {basis_expect_q, r};
        terms_sent++;
      end
      if (!in_valid_i || fire) begin
        offer = 1'b0;
        if (term_feed_q.size() != 0) begin
          if (term_feed_q[0].drain && (basis_expect_q.size() != 0 || drain_cnt < DRAIN_GAP)) begin
            drain_cnt = (basis_expect_q.size() != 0) ? 0 : drain_cnt + 1;
          end else if ((terms_sent >= 300 && terms_sent < 420) ||
                       $urandom_range(0, 99) >= STALL_PCT) begin
            offer = 1'b1;
          end
        end
        if (offer) begin
          cur_term      = term_feed_q.pop_front();
          drain_cnt     = 0;
          term_value_i  <= cur_term.value;
          term_cutoff_i <= cur_term.cutoff;
          term_order_i  <= cur_term.order;
          start_value_i <= cur_term.start;
          first_term_i  <= cur_term.first;
          last_term_i   <= cur_term.last;
        end
        in_valid_i <= offer;
      end
    end
  end

  // Receiver backpressure, with one long hold-off and one quiet stretch.
  int unsigned rx_cnt, hold_cnt;
  bit          hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_cnt      <= 0;
      hold_cnt    <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) rx_cnt <= rx_cnt + 1;
      if (hold_cnt != 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else if (rx_cnt >= 60 && !hold_done) begin
        hold_cnt    <= HOLD_LEN;
        hold_done   <= 1'b1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !(rx_cnt >= 130 && rx_cnt < 190) &&
                       ($urandom_range(0, 99) < STALL_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : mon_blk
    basis_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (basis_expect_q.size() == 0) begin
        $error("unexpected result transaction: basis_value %h", basis_value_o);
        fail_cnt++;
      end else begin
        want = basis_expect_q.pop_front();
        if (want.value == '0) zero_results++;
        if (want.saturated) sat_results++;
        if (basis_value_o !== want.value) begin
          $error("basis_value: expected %h, got %h", want.value, basis_value_o);
          fail_cnt++;
        end
        if (nonzero_o !== want.nonzero) begin
          $error("nonzero: expected %0b, got %0b", want.nonzero, nonzero_o);
          fail_cnt++;
        end
        if (saturated_o !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, saturated_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) timed_out <= 1'b1;
      end
    end
  end

  initial begin
    prod_q  = '0;
    dead_q  = 1'b0;
    clamp_q = 1'b0;

    // A term with no preceding first continues from the reset product of zero.
    push_term(32'h0003_0000, 32'h0001_0000, 1, ONE_FX, 0, 1, 0);
    // Single-term evaluations: order two, order zero, a kill, equal obs and cutoff.
    push_term(32'h0003_0000, 32'h0001_0000, 2, ONE_FX, 1, 1, 0);
    push_term(32'h0005_0000, 32'h0001_0000, 0, ONE_FX, 1, 1, 0);
    push_term(32'h0000_8000, 32'h0001_0000, 3, ONE_FX, 1, 1, 0);
    push_term(32'h1234_5678, 32'h1234_5678, 0, 32'h0002_8000, 1, 1, 0);
    // Zero start value, as for an inactive parent.
    push_term(32'h0004_0000, 32'h0001_0000, 1, 32'h0, 1, 1, 0);
    // Kill in the middle of a chain; later terms are ignored until the next first.
    push_term(32'h0003_0000, 32'h0001_0000, 1, ONE_FX, 1, 0, 0);
    push_term(32'hFFFF_0000, 32'h0000_0000, 2, ONE_FX, 0, 0, 0);
    push_term(32'h0009_0000, 32'h0001_0000, 3, ONE_FX, 0, 1, 0);
    // Clamp, then a zero factor: saturation stays set while the value drops to zero.
    push_term(32'h7FFF_FFFF, 32'h0000_0000, 3, 32'hFFFF_FFFF, 1, 1, 1);
    push_term(32'h0000_0000, 32'h0000_0000, 1, ONE_FX, 0, 1, 0);
    // Extreme fields: minimum obs and cutoff, and the widest positive difference.
    push_term(32'h8000_0000, 32'h8000_0000, 3, 32'hFFFF_FFFF, 1, 1, 0);
    push_term(32'h7FFF_FFFF, 32'h8000_0000, 1, ONE_FX, 1, 1, 0);
    push_term(32'h8000_0000, 32'h7FFF_FFFF, 2, 32'hFFFF_FFFF, 1, 1, 0);
    // Truncation of a tiny product to zero.
    push_term(32'h0000_0001, 32'h0000_0000, 1, 32'h0000_0001, 1, 1, 0);
    // Emitting a result keeps the state: terms after a last keep accumulating.
    push_term(32'h0002_0000, 32'h0000_0000, 1, ONE_FX, 1, 1, 0);
    push_term(32'h0003_0000, 32'h0000_0000, 1, ONE_FX, 0, 1, 0);
    push_term(32'h0002_8000, 32'h0000_8000, 3, ONE_FX, 0, 0, 0);
    push_term(32'h0001_0000, 32'h0000_0000, 2, ONE_FX, 0, 1, 0);

    while (items_built < NUM_ITEMS) build_random_chain();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out && (term_feed_q.size() != 0 || in_valid_i || basis_expect_q.size() != 0))
      @(posedge clk_i);
    if (!timed_out) repeat (4 * (tpbe_pkg::MAX_ORDER + 2)) @(posedge clk_i);

    if (timed_out) begin
      $error("no transaction for %0d cycles", WDOG_LIMIT);
      fail_cnt++;
    end
    if (basis_expect_q.size() != 0) begin
      $error("%0d expected basis results never arrived", basis_expect_q.size());
      fail_cnt++;
    end
    $display("Run covered %0d terms and %0d basis results (%0d zero, %0d saturated).",
             terms_sent, results_seen, zero_results, sat_results);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
